FILE: design/bbu_pkg.sv
// Shared types, constants and the microcode program of the belief update unit.
package bbu_pkg;

  // Q1.15 one.
  localparam logic [15:0] Q_ONE = 16'h8000;
  localparam logic [15:0] BELIEF_RESET = 16'h4000;

  // Configuration register indexes.
  localparam logic [2:0] REG_LIK_VV = 3'd0;
  localparam logic [2:0] REG_LIK_IV = 3'd1;
  localparam logic [2:0] REG_LIK_VI = 3'd2;
  localparam logic [2:0] REG_LIK_II = 3'd3;
  localparam logic [2:0] REG_SOFT_MODE = 3'd4;
  localparam logic [2:0] REG_VALID_THR = 3'd5;
  localparam logic [2:0] REG_INVALID_THR = 3'd6;

  localparam logic [15:0] LIK_VV_RESET = 16'd29491;
  localparam logic [15:0] LIK_IV_RESET = 16'd3277;
  localparam logic [15:0] LIK_VI_RESET = 16'd3277;
  localparam logic [15:0] LIK_II_RESET = 16'd29491;
  localparam logic [15:0] VALID_THR_RESET = 16'd29491;
  localparam logic [15:0] INVALID_THR_RESET = 16'd3277;

  // Belief state codes on the result.
  localparam logic [1:0] STATE_VALID = 2'd0;
  localparam logic [1:0] STATE_INVALID = 2'd1;
  localparam logic [1:0] STATE_UNKNOWN = 2'd2;

  // Quotient bits produced by the restoring divider.
  localparam int DIV_STEPS = 16;
  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam int PC_W = 4;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_MUL     = 3'd1,
    OP_DIVINIT = 3'd2,
    OP_DIVSTEP = 3'd3,
    OP_FINISH  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    X_VV = 3'd0,
    X_IV = 3'd1,
    X_VI = 3'd2,
    X_II = 3'd3,
    X_LV = 3'd4,
    X_LI = 3'd5
  } xsel_e;

  typedef enum logic [1:0] {
    Y_VC   = 2'd0,
    Y_NC   = 2'd1,
    Y_PRI  = 2'd2,
    Y_CPRI = 2'd3
  } ysel_e;

  typedef enum logic [2:0] {
    D_NONE = 3'd0,
    D_ACC  = 3'd1,
    D_LV   = 3'd2,
    D_LI   = 3'd3,
    D_DEN  = 3'd4
  } dst_e;

  typedef enum logic [1:0] {
    J_NONE      = 2'd0,
    J_DEN_ZERO  = 2'd1,
    J_DIV_AGAIN = 2'd2
  } jmp_e;

  typedef struct packed {
    op_e              op;
    xsel_e            x_sel;
    ysel_e            y_sel;
    logic             acc_add;
    dst_e             dst;
    jmp_e             jmp;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_DIVSTEP = 4'd7;
  localparam logic [PC_W-1:0] PC_FINISH = 4'd8;

  // Microcode store. Hard mode runs the same program with the valid
  // confidence forced to one or zero, which selects a single row.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{op: OP_NOP, x_sel: X_VV, y_sel: Y_VC, acc_add: 1'b0, dst: D_NONE,
          jmp: J_NONE, target: '0};
    case (pc)
      4'd0: begin
        c.op = OP_MUL; c.x_sel = X_VV; c.y_sel = Y_VC; c.dst = D_ACC;
      end
      4'd1: begin
        c.op = OP_MUL; c.x_sel = X_IV; c.y_sel = Y_NC; c.acc_add = 1'b1; c.dst = D_LV;
      end
      4'd2: begin
        c.op = OP_MUL; c.x_sel = X_VI; c.y_sel = Y_VC; c.dst = D_ACC;
      end
      4'd3: begin
        c.op = OP_MUL; c.x_sel = X_II; c.y_sel = Y_NC; c.acc_add = 1'b1; c.dst = D_LI;
      end
      4'd4: begin
        c.op = OP_MUL; c.x_sel = X_LV; c.y_sel = Y_PRI; c.dst = D_ACC;
      end
      4'd5: begin
        c.op = OP_MUL; c.x_sel = X_LI; c.y_sel = Y_CPRI; c.acc_add = 1'b1; c.dst = D_DEN;
      end
      4'd6: begin
        c.op = OP_DIVINIT; c.jmp = J_DEN_ZERO; c.target = PC_FINISH;
      end
      4'd7: begin
        c.op = OP_DIVSTEP; c.jmp = J_DIV_AGAIN; c.target = PC_DIVSTEP;
      end
      4'd8: begin
        c.op = OP_FINISH;
      end
      default: begin
        c.op = OP_NOP;
      end
    endcase
    return c;
  endfunction

  // Clamp a Q1.15 probability to one.
  function automatic logic [15:0] sat_prob(input logic [15:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

endpackage

FILE: design/bayes_belief_update_unit.sv
// Top level of the belief update unit: config registers, sequencer and datapath.
// The result beat is registered when the finish step completes; when the evidence is
// zero the divide is skipped and the program jumps straight to the finish step.
// The unit takes no new beat until the program finishes, which includes the 16 iterations
// of the one-bit-per-cycle restoring divider; a stalled result holds the final step.
// Reset idles the sequencer and output, restores register defaults, sets the belief to 1/2.
module bayes_belief_update_unit
  import bbu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Classifier result channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        predicted_invalid_i,
  input  logic [15:0] confidence_i,
  // Updated belief channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] belief_out_o,
  output logic [1:0]  belief_state_o,
  output logic        evidence_zero_o
);

  // Configuration registers. The port is always ready; the user must write them only
  // while idle; the block does not enforce this, and the datapath reads them directly.
  logic [15:0] lik_vv_q, lik_iv_q, lik_vi_q, lik_ii_q;
  logic [15:0] valid_thr_q, invalid_thr_q;
  logic        soft_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lik_vv_q      <= LIK_VV_RESET;
      lik_iv_q      <= LIK_IV_RESET;
      lik_vi_q      <= LIK_VI_RESET;
      lik_ii_q      <= LIK_II_RESET;
      soft_mode_q   <= 1'b0;
      valid_thr_q   <= VALID_THR_RESET;
      invalid_thr_q <= INVALID_THR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LIK_VV:      lik_vv_q <= cfg_data_i;
        REG_LIK_IV:      lik_iv_q <= cfg_data_i;
        REG_LIK_VI:      lik_vi_q <= cfg_data_i;
        REG_LIK_II:      lik_ii_q <= cfg_data_i;
        REG_SOFT_MODE:   soft_mode_q <= cfg_data_i[0];
        REG_VALID_THR:   valid_thr_q <= cfg_data_i;
        REG_INVALID_THR: invalid_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Likelihoods above one are saturated before use.
  logic [15:0] vv_sat, iv_sat, vi_sat, ii_sat;
  assign vv_sat = sat_prob(lik_vv_q);
  assign iv_sat = sat_prob(lik_iv_q);
  assign vi_sat = sat_prob(lik_vi_q);
  assign ii_sat = sat_prob(lik_ii_q);

  // Sequencer state. The unit takes a beat only when no program is running.
  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           ctl;
  logic            in_fire, fin_go;

  assign ctl        = ucode(pc_q);
  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;

  // The valid confidence is captured with the beat. In hard mode it is forced
  // to one for a valid prediction and zero for an invalid one, so the soft
  // mixing program picks exactly one row of the confusion matrix.
  logic [15:0] conf_sat, vc_in, vc_q, nc;
  assign conf_sat = sat_prob(confidence_i);

  always_comb begin
    if (soft_mode_q) begin
      vc_in = predicted_invalid_i ? (Q_ONE - conf_sat) : conf_sat;
    end else begin
      vc_in = predicted_invalid_i ? 16'd0 : Q_ONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      vc_q <= vc_in;
    end
  end

  assign nc = Q_ONE - vc_q;

  // Shared multiply-accumulate datapath: one 31x16 product per step.
  logic [15:0] belief_q, belief_d;
  logic [30:0] lv_q, li_q, x_op;
  logic [15:0] y_op;
  logic [45:0] acc_q, den_q;
  logic [46:0] prod, mac;

  always_comb begin
    case (ctl.x_sel)
      X_VV:    x_op = {15'd0, vv_sat};
      X_IV:    x_op = {15'd0, iv_sat};
      X_VI:    x_op = {15'd0, vi_sat};
      X_II:    x_op = {15'd0, ii_sat};
      X_LV:    x_op = lv_q;
      X_LI:    x_op = li_q;
      default: x_op = '0;
    endcase
  end

  always_comb begin
    case (ctl.y_sel)
      Y_VC:    y_op = vc_q;
      Y_NC:    y_op = nc;
      Y_PRI:   y_op = belief_q;
      Y_CPRI:  y_op = Q_ONE - belief_q;
      default: y_op = '0;
    endcase
  end

  assign prod = {16'd0, x_op} * {31'd0, y_op};
  assign mac  = prod + (ctl.acc_add ? {1'b0, acc_q} : 47'd0);

  always_ff @(posedge clk_i) begin
    if (busy_q && ctl.op == OP_MUL) begin
      case (ctl.dst)
        D_ACC:   acc_q <= mac[45:0];
        D_LV:    lv_q <= mac[30:0];
        D_LI:    li_q <= mac[30:0];
        D_DEN:   den_q <= mac[45:0];
        default: ;
      endcase
    end
  end

  // Restoring divider. The rounded dividend is num * 2^15 + den / 2; the
  // quotient is at most one in Q1.15, so sixteen quotient bits suffice and the
  // upper dividend bits already sit below the divisor.
  logic [60:0]      dividend;
  logic [45:0]      rem_q, rem_d;
  logic [15:0]      quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [46:0]      trial, diff;
  logic             trial_ge, den_zero;

  assign den_zero = (den_q == 46'd0);
  assign dividend = {acc_q, 15'd0} + {16'd0, den_q[45:1]};
  assign trial    = {rem_q, quo_q[15]};
  assign diff     = trial - {1'b0, den_q};
  assign trial_ge = (trial >= {1'b0, den_q});

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (busy_q && ctl.op == OP_DIVINIT) begin
      rem_d = {1'b0, dividend[60:16]};
      quo_d = dividend[15:0];
      cnt_d = '0;
    end else if (busy_q && ctl.op == OP_DIVSTEP) begin
      rem_d = trial_ge ? diff[45:0] : trial[45:0];
      quo_d = {quo_q[14:0], trial_ge};
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Program counter with conditional jumps. The finish step waits until the
  // output register is free, so a stalled result never gets overwritten.
  logic jump;

  always_comb begin
    case (ctl.jmp)
      J_DEN_ZERO:  jump = den_zero;
      J_DIV_AGAIN: jump = (cnt_q != CNT_W'(DIV_STEPS - 1));
      default:     jump = 1'b0;
    endcase
  end

  assign fin_go = busy_q && (ctl.op == OP_FINISH) && (!out_valid_o || out_ready_i);

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (in_fire) begin
        busy_d = 1'b1;
        pc_d   = '0;
      end
    end else if (ctl.op == OP_FINISH) begin
      if (fin_go) begin
        busy_d = 1'b0;
        pc_d   = '0;
      end
    end else begin
      pc_d = jump ? ctl.target : pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  // Posterior: clamp the rounded quotient to 1..one, or hold the belief when
  // the evidence is zero. The state is read from the belief that results.
  logic [1:0] state_d;

  always_comb begin
    if (den_zero) begin
      belief_d = belief_q;
    end else if (quo_q == 16'd0) begin
      belief_d = 16'd1;
    end else if (quo_q > Q_ONE) begin
      belief_d = Q_ONE;
    end else begin
      belief_d = quo_q;
    end
    if (belief_d >= valid_thr_q) begin
      state_d = STATE_VALID;
    end else if (belief_d <= invalid_thr_q) begin
      state_d = STATE_INVALID;
    end else begin
      state_d = STATE_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      belief_q <= BELIEF_RESET;
    end else if (fin_go) begin
      belief_q <= belief_d;
    end
  end

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      belief_out_o    <= belief_d;
      belief_state_o  <= state_d;
      evidence_zero_o <= den_zero;
    end
  end

  assign out_valid_o = out_valid_q;

  // The belief always stays a legal nonzero probability.
  a_belief_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (belief_q != 16'd0) && (belief_q <= Q_ONE))
    else $error("belief left the range 1..one");

  // A divide step never runs on a zero divisor and keeps its remainder reduced.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && ctl.op == OP_DIVSTEP) |-> (!den_zero && ({1'b0, rem_q} < {1'b0, den_q})))
    else $error("divider remainder not below divisor");

  // An accepted beat starts the program at its first step.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (busy_q && pc_q == '0))
    else $error("program did not start at step zero");

  // The finish step waits while a result is still held in the output register.
  a_finish_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && ctl.op == OP_FINISH && out_valid_q && !out_ready_i) |=>
      (busy_q && $stable(belief_q)))
    else $error("result finished over a stalled beat");

endmodule
